@@ rtl/elal_pkg.sv @@
`timescale 1ns / 1ps

package elal_pkg;

  localparam int unsigned NODE_W        = 10;
  localparam int unsigned LIMIT_W       = 11;
  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned MAX_EDGES_DEF = 4096;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ORDER  = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_RANGE  = 2'd3
  } status_e;

endpackage

@@ rtl/elal_seg_table.sv @@
`timescale 1ns / 1ps

module elal_seg_table #(
  parameter int unsigned DEPTH = elal_pkg::MAX_NODES_DEF,
  parameter int unsigned DW    = 13
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/elal_edge_store.sv @@
`timescale 1ns / 1ps

module elal_edge_store #(
  parameter int unsigned DEPTH = elal_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [elal_pkg::NODE_W-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  input  logic [elal_pkg::NODE_W-1:0]   key_i,
  output logic                          hit_o
);

  logic [elal_pkg::NODE_W-1:0] mem_q [DEPTH];
  logic [elal_pkg::NODE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // The stored target read in the previous cycle is compared against the key.
  assign hit_o = (rdata_q == key_i);

endmodule

@@ rtl/edge_list_adjacency_lookup_unit.sv @@
`timescale 1ns / 1ps

// Edge list adjacency lookup in compressed sparse row form.
// A command is taken on a rising edge where start is high and busy is low;
// command_i selects clear, load one edge (node_a_i -> node_b_i) or query
// whether node_a_i and node_b_i are adjacent. Each command gives one result:
// done_o is high for exactly one cycle with found_o and status_o, and the
// receiver takes it in that cycle; it cannot stall the block.
// Clear, the unused command, every rejected request and a query with no segment
// to scan answer in the cycle after the transfer. A load fills one skipped node
// segment per cycle through the segment table write port and answers once the
// segment of node_a_i is written. A query reads two segment offsets from the
// segment table (one when the smaller node is node 0), then scans the segment
// through the edge store one stored edge per cycle with one shared comparator
// and stops at the first match.
// busy stays high while a command is in progress.
// The node_limit register is written over the cfg channel (always ready) and
// is meant to be written only while the block is idle.
// Reset empties the store and sets node_limit to 1024; no clearing pass runs
// over the memories, so the block takes a command right after reset.
module edge_list_adjacency_lookup_unit #(
  parameter int unsigned MAX_NODES = elal_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = elal_pkg::MAX_EDGES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     command_i,
  input  logic [elal_pkg::NODE_W-1:0]    node_a_i,
  input  logic [elal_pkg::NODE_W-1:0]    node_b_i,
  output logic                           done_o,
  output logic                           found_o,
  output logic [1:0]                     status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [elal_pkg::LIMIT_W-1:0]   cfg_node_limit_i
);

  localparam int unsigned NW        = elal_pkg::NODE_W;
  localparam int unsigned SEG_DEPTH = (MAX_NODES < (1 << NW)) ? MAX_NODES : (1 << NW);
  localparam int unsigned SEG_AW    = $clog2(SEG_DEPTH);
  localparam int unsigned EAW       = $clog2(MAX_EDGES);
  localparam int unsigned ECW       = $clog2(MAX_EDGES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SEG_START,
    ST_SEG_STOP,
    ST_SCAN
  } state_e;

  state_e                       state_q;
  logic [elal_pkg::LIMIT_W-1:0] limit_q;
  logic [ECW-1:0]               edge_count_q;
  logic [NW-1:0]                last_q;
  logic                         any_q;
  logic [NW-1:0]                src_q;
  logic [NW-1:0]                dst_q;
  logic [NW-1:0]                lo_q;
  logic [NW-1:0]                hi_q;
  logic [NW:0]                  fill_q;
  logic [ECW-1:0]               ptr_q;
  logic [ECW-1:0]               stop_q;
  logic                         pend_q;
  logic                         done_q;
  logic                         found_q;
  logic [1:0]                   status_q;

  logic          range_bad;
  logic [NW-1:0] lo_in;
  logic [NW-1:0] hi_in;
  logic [NW-1:0] seg_rd_node;
  logic          fill_more;
  logic          seg_we;
  logic [SEG_AW-1:0] seg_waddr;
  logic [ECW-1:0]    seg_wdata;
  logic              seg_re;
  logic [SEG_AW-1:0] seg_raddr;
  logic [ECW-1:0]    seg_rdata;
  logic              edge_we;
  logic              edge_re;
  logic              edge_hit;
  logic              scan_hit;

  assign range_bad = ({1'b0, node_a_i} >= limit_q) || ({1'b0, node_b_i} >= limit_q)
                  || (32'(node_a_i) >= MAX_NODES) || (32'(node_b_i) >= MAX_NODES);

  assign lo_in = (node_a_i < node_b_i) ? node_a_i : node_b_i;
  assign hi_in = (node_a_i < node_b_i) ? node_b_i : node_a_i;

  assign fill_more = (fill_q < {1'b0, src_q});

  assign seg_we    = (state_q == ST_FILL);
  assign seg_waddr = fill_more ? fill_q[SEG_AW-1:0] : src_q[SEG_AW-1:0];
  assign seg_wdata = fill_more ? edge_count_q : edge_count_q + ECW'(1);

  assign seg_rd_node = (state_q == ST_IDLE)
                     ? ((lo_in == '0) ? lo_in : lo_in - NW'(1))
                     : lo_q;
  assign seg_raddr   = seg_rd_node[SEG_AW-1:0];
  assign seg_re      = ((state_q == ST_IDLE) && start) || (state_q == ST_SEG_START);

  assign scan_hit = pend_q && edge_hit;
  assign edge_we  = (state_q == ST_FILL) && !fill_more;
  assign edge_re  = (state_q == ST_SCAN) && !scan_hit && (ptr_q != stop_q);

  elal_seg_table #(
    .DEPTH (SEG_DEPTH),
    .DW    (ECW)
  ) u_seg (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (seg_wdata),
    .re_i    (seg_re),
    .raddr_i (seg_raddr),
    .rdata_o (seg_rdata)
  );

  elal_edge_store #(
    .DEPTH (MAX_EDGES)
  ) u_edges (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_count_q[EAW-1:0]),
    .wdata_i (dst_q),
    .re_i    (edge_re),
    .raddr_i (ptr_q[EAW-1:0]),
    .key_i   (hi_q),
    .hit_o   (edge_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= elal_pkg::LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_node_limit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      edge_count_q <= '0;
      last_q       <= '0;
      any_q        <= 1'b0;
      src_q        <= '0;
      dst_q        <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      fill_q       <= '0;
      ptr_q        <= '0;
      stop_q       <= '0;
      pend_q       <= 1'b0;
      done_q       <= 1'b0;
      found_q      <= 1'b0;
      status_q     <= elal_pkg::STATUS_OK;
    end else begin
      done_q  <= 1'b0;
      found_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            status_q <= elal_pkg::STATUS_OK;
            case (elal_pkg::cmd_e'(command_i))
              elal_pkg::CMD_CLEAR: begin
                edge_count_q <= '0;
                last_q       <= '0;
                any_q        <= 1'b0;
                done_q       <= 1'b1;
              end
              elal_pkg::CMD_LOAD: begin
                if (range_bad) begin
                  status_q <= elal_pkg::STATUS_RANGE;
                  done_q   <= 1'b1;
                end else if (any_q && (node_a_i < last_q)) begin
                  status_q <= elal_pkg::STATUS_ORDER;
                  done_q   <= 1'b1;
                end else if (edge_count_q == ECW'(MAX_EDGES)) begin
                  status_q <= elal_pkg::STATUS_FULL;
                  done_q   <= 1'b1;
                end else begin
                  src_q   <= node_a_i;
                  dst_q   <= node_b_i;
                  fill_q  <= any_q ? {1'b0, last_q} + (NW + 1)'(1) : '0;
                  state_q <= ST_FILL;
                end
              end
              elal_pkg::CMD_QUERY: begin
                lo_q <= lo_in;
                hi_q <= hi_in;
                if (range_bad) begin
                  status_q <= elal_pkg::STATUS_RANGE;
                  done_q   <= 1'b1;
                end else if (!any_q || (lo_in > last_q)) begin
                  done_q <= 1'b1;
                end else if (lo_in == '0) begin
                  ptr_q   <= '0;
                  state_q <= ST_SEG_STOP;
                end else begin
                  state_q <= ST_SEG_START;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        ST_FILL: begin
          if (fill_more) begin
            fill_q <= fill_q + (NW + 1)'(1);
          end else begin
            edge_count_q <= edge_count_q + ECW'(1);
            last_q       <= src_q;
            any_q        <= 1'b1;
            done_q       <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        ST_SEG_START: begin
          ptr_q   <= seg_rdata;
          state_q <= ST_SEG_STOP;
        end
        ST_SEG_STOP: begin
          stop_q  <= seg_rdata;
          pend_q  <= 1'b0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_hit) begin
            found_q <= 1'b1;
            done_q  <= 1'b1;
            pend_q  <= 1'b0;
            state_q <= ST_IDLE;
          end else if (ptr_q == stop_q) begin
            done_q  <= 1'b1;
            pend_q  <= 1'b0;
            state_q <= ST_IDLE;
          end else begin
            ptr_q  <= ptr_q + ECW'(1);
            pend_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign found_o     = found_q;
  assign status_o    = status_q;

endmodule

@@ rtl/elal_checker.sv @@
`timescale 1ns / 1ps

module elal_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic       found_o,
  input logic [1:0] status_o
);

  // A result appears only while the block is ready for the next command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Every accepted command either answers at once or keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither answered nor in progress");

  // Leaving the busy phase always delivers the result of that command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // A result follows either a transfer or a cycle of work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a command");

  // A found edge is never reported together with an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == elal_pkg::STATUS_OK))
    else $error("found flag with error status");

endmodule

bind edge_list_adjacency_lookup_unit elal_checker u_elal_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .found_o  (found_o),
  .status_o (status_o)
);
